/* rtl/u8u16_pkg.sv */
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 decoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

    typedef enum logic [1:0] {
        KIND_UNIT   = 2'd0,
        KIND_OK     = 2'd1,
        KIND_FAILED = 2'd2
    } kind_t;

    typedef struct packed {
        logic [15:0] code_unit;
        kind_t       result_kind;
        logic        last_of_run;
    } result_t;

    localparam int unsigned MAX_RESULTS = 3;
    localparam int unsigned CNT_W       = 2;

    localparam logic [20:0] MIN_TWO_BYTE   = 21'h00080;
    localparam logic [20:0] MIN_THREE_BYTE = 21'h00800;
    localparam logic [20:0] MIN_FOUR_BYTE  = 21'h10000;
    localparam logic [20:0] SURR_LOW       = 21'd55296;
    localparam logic [20:0] SURR_HIGH      = 21'd57343;
    localparam logic [20:0] MAX_CODE_POINT = 21'd1114111;
    localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
    localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;

endpackage

/* rtl/u8u16_in_if.sv */
// ----------------------------------------------------------------------------
// u8u16_in_if
// Byte channel into the decoder: one UTF-8 byte and string framing.
// ----------------------------------------------------------------------------
interface u8u16_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_string;

    modport source (output valid, data_byte, byte_present, end_of_string, input ready);
    modport sink   (input valid, data_byte, byte_present, end_of_string, output ready);
endinterface

/* rtl/u8u16_out_if.sv */
// ----------------------------------------------------------------------------
// u8u16_out_if
// Result channel out of the decoder: code units and string status.
// ----------------------------------------------------------------------------
interface u8u16_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic [1:0]  result_kind;
    logic        last_of_run;

    modport source (output valid, code_unit, result_kind, last_of_run, input ready);
    modport sink   (input valid, code_unit, result_kind, last_of_run, output ready);
endinterface

/* rtl/utf8_to_utf16_decoder_top.sv */
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_top
// Decodes a framed UTF-8 byte stream into UTF-16 code units and one status
// result per string.
// ----------------------------------------------------------------------------
// An input byte is decoded in the cycle it transfers and its results (none,
// one or two code units, plus the status when it closes the string) are
// loaded into a three-entry result buffer that drains one result per cycle
// while the output is ready. A byte that causes at most one result is taken
// every cycle while the output is ready; a byte with more results holds the
// input, since the next transfer is taken only when the buffer is empty or its
// last entry leaves in the same cycle. First result appears the cycle after.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder_top (
    input  logic        clk,
    input  logic        rst_n,
    u8u16_in_if.sink    byte_in,
    u8u16_out_if.source unit_out
);
    import u8u16_pkg::*;

    logic [1:0]  exp_reg, exp_next;
    logic [1:0]  len_reg, len_next;
    logic [20:0] acc_reg, acc_next;
    logic        failed_reg, failed_next;

    result_t           buf_reg [MAX_RESULTS];
    result_t           buf_next [MAX_RESULTS];
    result_t           res_new [MAX_RESULTS];
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  n_new;

    logic        in_xfer;
    logic        out_xfer;
    logic [7:0]  b;
    logic [20:0] acc_shift;
    logic [20:0] v_off;
    logic [1:0]  exp_dec;
    logic        good;
    logic        fail;

    assign out_xfer       = unit_out.valid && unit_out.ready;
    assign byte_in.ready  = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && unit_out.ready);
    assign in_xfer        = byte_in.valid && byte_in.ready;

    assign unit_out.valid       = (cnt_reg != '0);
    assign unit_out.code_unit   = buf_reg[0].code_unit;
    assign unit_out.result_kind = buf_reg[0].result_kind;
    assign unit_out.last_of_run = buf_reg[0].last_of_run;

    assign b         = byte_in.data_byte;
    assign acc_shift = {acc_reg[14:0], b[5:0]};
    assign v_off     = acc_shift - MIN_FOUR_BYTE;
    assign exp_dec   = exp_reg - 2'd1;

    always_comb
    begin
        exp_next    = exp_reg;
        len_next    = len_reg;
        acc_next    = acc_reg;
        failed_next = failed_reg;
        n_new       = '0;
        fail        = 1'b0;
        good        = 1'b0;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            res_new[i] = '{code_unit: 16'h0, result_kind: KIND_UNIT, last_of_run: 1'b0};
        end

        if (byte_in.byte_present && !failed_reg)
        begin
            if (exp_reg == 2'd0)
            begin
                if (b[7] == 1'b0)
                begin
                    res_new[0].code_unit = {8'h00, b};
                    n_new = CNT_W'(1);
                end
                else if (b[7:5] == 3'b110)
                begin
                    acc_next = {16'h0, b[4:0]};
                    len_next = 2'd1;
                    exp_next = 2'd1;
                end
                else if (b[7:4] == 4'b1110)
                begin
                    acc_next = {17'h0, b[3:0]};
                    len_next = 2'd2;
                    exp_next = 2'd2;
                end
                else if (b[7:3] == 5'b11110)
                begin
                    acc_next = {18'h0, b[2:0]};
                    len_next = 2'd3;
                    exp_next = 2'd3;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            else if (b[7:6] != 2'b10)
            begin
                fail = 1'b1;
            end
            else if (exp_dec != 2'd0)
            begin
                acc_next = acc_shift;
                exp_next = exp_dec;
            end
            else
            begin
                unique case (len_reg)
                    2'd1:    good = (acc_shift >= MIN_TWO_BYTE);
                    2'd2:    good = (acc_shift >= MIN_THREE_BYTE)
                                    && ((acc_shift < SURR_LOW) || (acc_shift > SURR_HIGH));
                    default: good = (acc_shift >= MIN_FOUR_BYTE)
                                    && (acc_shift <= MAX_CODE_POINT);
                endcase
                exp_next = 2'd0;
                len_next = 2'd0;
                acc_next = '0;
                if (!good)
                begin
                    fail = 1'b1;
                end
                else if (acc_shift < MIN_FOUR_BYTE)
                begin
                    res_new[0].code_unit = acc_shift[15:0];
                    n_new = CNT_W'(1);
                end
                else
                begin
                    res_new[0].code_unit = HIGH_SURR_BASE | {6'h0, v_off[19:10]};
                    res_new[1].code_unit = LOW_SURR_BASE | {6'h0, v_off[9:0]};
                    n_new = CNT_W'(2);
                end
            end
        end

        if (fail)
        begin
            failed_next = 1'b1;
            exp_next    = 2'd0;
            len_next    = 2'd0;
            acc_next    = '0;
        end

        if (byte_in.end_of_string)
        begin
            res_new[n_new].result_kind = (failed_next || (exp_next != 2'd0))
                                         ? KIND_FAILED : KIND_OK;
            n_new       = n_new + CNT_W'(1);
            exp_next    = 2'd0;
            len_next    = 2'd0;
            acc_next    = '0;
            failed_next = 1'b0;
        end

        if (n_new != '0)
        begin
            res_new[n_new - CNT_W'(1)].last_of_run = 1'b1;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            buf_next[i] = buf_reg[i];
        end
        if (out_xfer)
        begin
            buf_next[0] = buf_reg[1];
            buf_next[1] = buf_reg[2];
            cnt_next    = cnt_reg - CNT_W'(1);
        end
        if (in_xfer)
        begin
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                buf_next[i] = res_new[i];
            end
            cnt_next = n_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg    <= '0;
            len_reg    <= '0;
            acc_reg    <= '0;
            failed_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (in_xfer)
            begin
                exp_reg    <= exp_next;
                len_reg    <= len_next;
                acc_reg    <= acc_next;
                failed_reg <= failed_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            buf_reg[i] <= buf_next[i];
        end
    end

endmodule

/* rtl/u8u16_checker.sv */
// ----------------------------------------------------------------------------
// u8u16_checker
// Port-level checks for the UTF-8 to UTF-16 decoder, bound to the top level.
// ----------------------------------------------------------------------------
module u8u16_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] code_unit,
    input logic [1:0]  result_kind,
    input logic        last_of_run
);
    import u8u16_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(code_unit) && $stable(result_kind) && $stable(last_of_run)))
        else $error("result changed while stalled");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (result_kind == KIND_UNIT || result_kind == KIND_OK
                       || result_kind == KIND_FAILED))
        else $error("illegal result kind");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind != KIND_UNIT) |-> (last_of_run && code_unit == 16'h0))
        else $error("status result not last or carries a unit");

    // a high surrogate is always followed by its low surrogate from the same byte
    a_surr_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && result_kind == KIND_UNIT && code_unit[15:10] == 6'b110110)
            |-> (!last_of_run ##1 (out_valid && result_kind == KIND_UNIT
                                   && code_unit[15:10] == 6'b110111)))
        else $error("high surrogate without low surrogate");

endmodule

bind utf8_to_utf16_decoder_top u8u16_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (unit_out.valid),
    .out_ready   (unit_out.ready),
    .code_unit   (unit_out.code_unit),
    .result_kind (unit_out.result_kind),
    .last_of_run (unit_out.last_of_run)
);
